FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

FILE: rtl/mffp_pkg.sv
// ---------------------------------------------------------------------------
// mffp_pkg
// types and codes shared by the motor feedback frame parser
// ---------------------------------------------------------------------------
package mffp_pkg;

	// response function codes and sign marker
	localparam logic [7:0] CODE_SPEED    = 8'h35;
	localparam logic [7:0] CODE_PULSES   = 8'h32;
	localparam logic [7:0] SIGN_NEGATIVE = 8'h01;

	// minimum payload length per code
	localparam logic [3:0] LEN_SPEED  = 4'd4;
	localparam logic [3:0] LEN_PULSES = 4'd6;

	// highest motor address that a 4-bit address register can name
	localparam int CFG_ADDR_MAX = 15;

	// configuration register indexes
	localparam logic [2:0] CFG_FRONT_LEFT  = 3'd0;
	localparam logic [2:0] CFG_FRONT_RIGHT = 3'd1;
	localparam logic [2:0] CFG_REAR_LEFT   = 3'd2;
	localparam logic [2:0] CFG_REAR_RIGHT  = 3'd3;
	localparam logic [2:0] CFG_VERT_ARM    = 3'd4;
	localparam logic [2:0] CFG_HORIZ_ARM   = 3'd5;
	localparam int         CFG_COUNT       = 6;
	localparam int         WHEEL_COUNT     = 4;

	typedef enum logic [2:0] {
		ST_IGNORED        = 3'd0,
		ST_SPEED_STORED   = 3'd1,
		ST_WHEELS_DONE    = 3'd2,
		ST_PULSES_STORED  = 3'd3,
		ST_SNAPSHOT_TAKEN = 3'd4,
		ST_NONE_READY     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ARM_NONE  = 2'd0,
		ARM_VERT  = 2'd1,
		ARM_HORIZ = 2'd2
	} arm_axis_t;

	typedef enum logic {
		FUNC_FRAME = 1'b0,
		FUNC_TAKE  = 1'b1
	} func_t;

	typedef logic [CFG_COUNT-1:0][3:0] addr_set_t;

	// one input word
	typedef struct packed {
		func_t       func;
		logic [28:0] ext_id;
		logic [3:0]  frame_length;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [7:0]  byte4;
		logic [7:0]  byte5;
	} frame_t;

	// one result word
	typedef struct packed {
		status_t                       status;
		logic [WHEEL_COUNT-1:0][15:0]  wheel;
		arm_axis_t                     arm_axis;
		logic [31:0]                   arm_pulse_count;
	} result_t;

endpackage

FILE: rtl/motor_feedback_frame_parser_top.sv
// ---------------------------------------------------------------------------
// motor_feedback_frame_parser_top
// decodes motor-driver response frames into wheel snapshots and arm pulses
// ---------------------------------------------------------------------------
// One word is taken per clock while in_stall is low, and each gives exactly one
// result word, held first in the input register and then in the result
// register. The rate is set by the single decode pass between those
// two registers, which also updates the speed table and snapshot, so a word
// sees everything the word before it left. The user must write the address
// registers through cfg_write/cfg_index/cfg_data only while the block is idle;
// the block itself does not enforce this. Indexes past the list are dropped.
module motor_feedback_frame_parser_top import mffp_pkg::*; #(
	parameter int MOTOR_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [28:0]        ext_id,
	input  logic [3:0]         frame_length,
	input  logic [7:0]         byte0,
	input  logic [7:0]         byte1,
	input  logic [7:0]         byte2,
	input  logic [7:0]         byte3,
	input  logic [7:0]         byte4,
	input  logic [7:0]         byte5,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [15:0] wheel_front_left,
	output logic signed [15:0] wheel_front_right,
	output logic signed [15:0] wheel_rear_left,
	output logic signed [15:0] wheel_rear_right,
	output logic [1:0]         arm_axis,
	output logic signed [31:0] arm_pulse_count
);

	addr_set_t cfg_q;
	logic      valid_s1;
	frame_t    frame_s1;
	logic      valid_s2;
	result_t   result_s2;
	result_t   result;
	logic      advance;
	logic      fire;

	// address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++) begin
				cfg_q[i] <= 4'(i + 1);
			end
		end else if (cfg_write && (32'(cfg_index) < CFG_COUNT)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// handshake: stage 1 moves on when the result register is free or draining
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			frame_s1 <= '{func: func_t'(func), ext_id: ext_id, frame_length: frame_length,
			              byte0: byte0, byte1: byte1, byte2: byte2, byte3: byte3,
			              byte4: byte4, byte5: byte5};
		end
	end

	// decode and state
	mffp_core #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.frame (frame_s1),
		.cfg   (cfg_q),
		.result(result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	// output word
	assign out_valid         = valid_s2;
	assign status            = result_s2.status;
	assign wheel_front_left  = result_s2.wheel[0];
	assign wheel_front_right = result_s2.wheel[1];
	assign wheel_rear_left   = result_s2.wheel[2];
	assign wheel_rear_right  = result_s2.wheel[3];
	assign arm_axis          = result_s2.arm_axis;
	assign arm_pulse_count   = result_s2.arm_pulse_count;

endmodule

FILE: rtl/mffp_core.sv
// ---------------------------------------------------------------------------
// mffp_core
// per-motor speed table, wheel set tracking and snapshot; decodes one frame
// ---------------------------------------------------------------------------
module mffp_core import mffp_pkg::*; #(
	parameter int MOTOR_COUNT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  frame_t    frame,
	input  addr_set_t cfg,
	output result_t   result
);

	// only motors a 4-bit register can name are ever read back
	localparam int                SLOTS    = (MOTOR_COUNT < CFG_ADDR_MAX) ? MOTOR_COUNT
	                                                                      : CFG_ADDR_MAX;
	localparam logic [7:0]        MAX_ADDR = 8'(MOTOR_COUNT);

	logic [SLOTS-1:0][15:0] speed_q;
	logic [SLOTS-1:0]       fresh_q;
	logic [WHEEL_COUNT-1:0][15:0] snap_q;
	logic                   snap_ready_q;

	logic [7:0]             addr;
	logic                   in_range;
	logic                   is_speed;
	logic                   is_pulse;
	logic [15:0]            speed_raw;
	logic [31:0]            pulse_raw;
	logic [SLOTS-1:0][15:0] speed_upd;
	logic [SLOTS-1:0]       fresh_upd;
	logic [SLOTS-1:0]       fresh_next;
	logic [WHEEL_COUNT-1:0] wheel_fresh;
	logic [WHEEL_COUNT-1:0][15:0] wheel_speed;
	logic                   complete;
	logic                   vert_hit;
	logic                   horiz_hit;

	// frame classification and sign-magnitude values
	always_comb begin
		addr      = frame.ext_id[15:8];
		in_range  = (addr != 8'd0) && (addr <= MAX_ADDR);
		is_speed  = (frame.func == FUNC_FRAME) && in_range && (frame.byte0 == CODE_SPEED)
		            && (frame.frame_length >= LEN_SPEED);
		is_pulse  = (frame.func == FUNC_FRAME) && in_range && (frame.byte0 == CODE_PULSES)
		            && (frame.frame_length >= LEN_PULSES);
		speed_raw = {frame.byte2, frame.byte3};
		pulse_raw = {frame.byte2, frame.byte3, frame.byte4, frame.byte5};
		if (frame.byte1 == SIGN_NEGATIVE) begin
			speed_raw = 16'd0 - speed_raw;
			pulse_raw = 32'd0 - pulse_raw;
		end
	end

	// speed table as it stands after this frame's write
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			if (is_speed && (addr == 8'(i + 1))) begin
				speed_upd[i] = speed_raw;
				fresh_upd[i] = 1'b1;
			end else begin
				speed_upd[i] = speed_q[i];
				fresh_upd[i] = fresh_q[i];
			end
		end
	end

	// wheel lookups; an address of zero or past the table is never fresh
	always_comb begin
		for (int k = 0; k < WHEEL_COUNT; k++) begin
			wheel_fresh[k] = 1'b0;
			wheel_speed[k] = 16'd0;
			for (int i = 0; i < SLOTS; i++) begin
				if (cfg[k] == 4'(i + 1)) begin
					wheel_fresh[k] = fresh_upd[i];
					wheel_speed[k] = speed_upd[i];
				end
			end
		end
		complete = is_speed && (&wheel_fresh);
	end

	// clear fresh marks of the wheels once the set completes
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			fresh_next[i] = fresh_upd[i];
			for (int k = 0; k < WHEEL_COUNT; k++) begin
				if (complete && (cfg[k] == 4'(i + 1))) begin
					fresh_next[i] = 1'b0;
				end
			end
		end
	end

	// arm match, vertical axis wins on a shared address
	always_comb begin
		vert_hit  = is_pulse && ({4'd0, cfg[CFG_VERT_ARM]} == addr);
		horiz_hit = is_pulse && !vert_hit && ({4'd0, cfg[CFG_HORIZ_ARM]} == addr);
	end

	// result word
	always_comb begin
		result = '0;
		result.status   = ST_IGNORED;
		result.arm_axis = ARM_NONE;
		if (frame.func == FUNC_TAKE) begin
			if (snap_ready_q) begin
				result.status = ST_SNAPSHOT_TAKEN;
				result.wheel  = snap_q;
			end else begin
				result.status = ST_NONE_READY;
			end
		end else if (is_speed) begin
			if (complete) begin
				result.status = ST_WHEELS_DONE;
				result.wheel  = wheel_speed;
			end else begin
				result.status = ST_SPEED_STORED;
			end
		end else if (is_pulse) begin
			result.status = ST_PULSES_STORED;
			if (vert_hit) begin
				result.arm_axis        = ARM_VERT;
				result.arm_pulse_count = pulse_raw;
			end else if (horiz_hit) begin
				result.arm_axis        = ARM_HORIZ;
				result.arm_pulse_count = pulse_raw;
			end
		end
	end

	// speed table and fresh marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			fresh_q <= '0;
		end else if (fire) begin
			speed_q <= speed_upd;
			fresh_q <= fresh_next;
		end
	end

	// snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q       <= '0;
			snap_ready_q <= 1'b0;
		end else if (fire) begin
			if (frame.func == FUNC_TAKE) begin
				snap_ready_q <= 1'b0;
			end else if (complete) begin
				snap_q       <= wheel_speed;
				snap_ready_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/mffp_checker.sv
// ---------------------------------------------------------------------------
// mffp_checker
// port-level properties of the motor feedback frame parser
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mffp_checker import mffp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] wheel_front_left,
	input logic [15:0] wheel_front_right,
	input logic [15:0] wheel_rear_left,
	input logic [15:0] wheel_rear_right,
	input logic [1:0]  arm_axis,
	input logic [31:0] arm_pulse_count
);

	// a stalled output word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(arm_pulse_count))

	// speeds only show with a completed set or a taken snapshot
	`ASSERT_IMPLY(a_wheels_zero, clk, arst_n, out_valid && (status != ST_WHEELS_DONE) && (status != ST_SNAPSHOT_TAKEN), (wheel_front_left == 16'd0) && (wheel_front_right == 16'd0) && (wheel_rear_left == 16'd0) && (wheel_rear_right == 16'd0))

	// no arm axis, no pulse count
	`ASSERT_IMPLY(a_pulse_zero, clk, arst_n, out_valid && (arm_axis == ARM_NONE), arm_pulse_count == 32'd0)

	// an arm report comes only with a stored pulse frame
	`ASSERT_IMPLY(a_arm_status, clk, arst_n, out_valid && (arm_axis != ARM_NONE), status == ST_PULSES_STORED)

endmodule

bind motor_feedback_frame_parser_top mffp_checker u_mffp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.status           (status),
	.wheel_front_left (wheel_front_left),
	.wheel_front_right(wheel_front_right),
	.wheel_rear_left  (wheel_rear_left),
	.wheel_rear_right (wheel_rear_right),
	.arm_axis         (arm_axis),
	.arm_pulse_count  (arm_pulse_count)
);
